// ===== sv/cbm_pkg.sv =====
package cbm_pkg;

	localparam int unsigned ADDR_W      = 16;
	localparam int unsigned DATA_W      = 8;
	localparam int unsigned TARGET_W    = 3;
	localparam int unsigned OFFSET_W    = 23;
	localparam int unsigned CFG_DATA_W  = 10;
	localparam int unsigned CFG_IDX_W   = 2;

	localparam int unsigned ROM_CNT_W   = 10;
	localparam int unsigned RAM_CNT_W   = 5;
	localparam int unsigned ROM_SEL_W   = 9;
	localparam int unsigned RAM_SEL_W   = 4;

	// remainder unit: dividend is the widest bank select, divisor the widest count
	localparam int unsigned DVD_W       = ROM_SEL_W;
	localparam int unsigned DVS_W       = ROM_CNT_W;
	localparam int unsigned CNT_W       = $clog2(DVD_W + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_PRESENT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RUMBLE_CART    = 2'd3;

	localparam logic [ROM_CNT_W-1:0] ROM_COUNT_RST  = 10'd2;
	localparam logic [ROM_SEL_W-1:0] ROM_SEL_RST    = 9'd1;
	localparam logic [DATA_W-1:0]    RAM_EN_KEY     = 8'h0A;
	localparam logic [ADDR_W-1:0]    CTRL_LAST_ADDR = 16'h5FFF;

	typedef enum logic [TARGET_W-1:0] {
		TGT_FIXED_ROM = 3'd0,
		TGT_BANK_ROM  = 3'd1,
		TGT_CART_RAM  = 3'd2,
		TGT_RAM_OFF   = 3'd3,
		TGT_CONTROL   = 3'd4,
		TGT_OTHER     = 3'd5
	} cbm_target_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} cbm_mod_req_t;

	typedef struct packed {
		logic             done;
		logic [DVS_W-1:0] rem;
	} cbm_mod_rsp_t;

endpackage

// ===== sv/cbm_if.sv =====
interface cbm_in_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [cbm_pkg::ADDR_W-1:0]    bus_addr;
	logic [cbm_pkg::DATA_W-1:0]    wdata;

	modport source (output valid, output op, output bus_addr, output wdata, input ready);
	modport sink (input valid, input op, input bus_addr, input wdata, output ready);
endinterface

interface cbm_out_if;
	logic                          valid;
	logic                          ready;
	logic [cbm_pkg::TARGET_W-1:0]  target;
	logic [cbm_pkg::OFFSET_W-1:0]  phys_offset;
	logic                          ram_writable;

	modport source (output valid, output target, output phys_offset, output ram_writable,
		input ready);
	modport sink (input valid, input target, input phys_offset, input ram_writable,
		output ready);
endinterface

// ===== sv/cbm_mod_unit.sv =====
// Restoring remainder, one dividend bit per cycle. A zero divisor yields zero.
module cbm_mod_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cbm_pkg::cbm_mod_req_t req,
	output cbm_pkg::cbm_mod_rsp_t rsp
);

	logic [cbm_pkg::DVD_W-1:0] dvd_q;
	logic [cbm_pkg::DVS_W-1:0] dvs_q;
	logic [cbm_pkg::DVS_W-1:0] rem_q;
	logic [cbm_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;

	logic [cbm_pkg::DVS_W:0]   trial;
	logic [cbm_pkg::DVS_W:0]   diff;
	logic                      take;

	assign trial = {rem_q, dvd_q[cbm_pkg::DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cbm_pkg::CNT_W'(cbm_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - cbm_pkg::CNT_W'(1);
				if (cnt_q == cbm_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[cbm_pkg::DVD_W-2:0], 1'b0};
			rem_q <= take ? diff[cbm_pkg::DVS_W-1:0] : trial[cbm_pkg::DVS_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = (dvs_q == '0) ? '0 : rem_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.start && busy_q))
		else $error("remainder unit restarted while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("done without preceding iteration");

	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("iteration count ran out while busy");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && dvs_q != '0) |-> rem_q < dvs_q)
		else $error("remainder not below divisor");

endmodule

// ===== sv/cartridge_bank_mapper.sv =====
// Bank mapper for a cartridge bus: one CPU access in, one mapping result out.
// in_ch carries op (0 read, 1 write), bus_addr and wdata; out_ch returns
// target, phys_offset and ram_writable. Both use valid/ready; a transfer
// happens on a clock edge with valid and ready high.
// The config port (cfg_we, cfg_index, cfg_wdata) sets bank counts, RAM
// presence and the rumble flag; write it only while no access is in flight.
// Control writes, fixed ROM, unmapped RAM and other addresses pass from the
// input transfer through the finish state into the output register.
// Banked ROM and mapped RAM accesses run the bank select through a shared
// remainder unit that resolves one bit per cycle over 9 bits; the result is
// stored when the unit is done, and the finish state moves it to the output.
// One access is in flight at a time; in_ch.ready is high only while the
// sequencer is idle. A finished result sits in the output register while
// the next access is accepted; if the receiver stalls, the following result
// waits in the sequencer until the output register frees.
// Reset: RAM disabled, ROM bank 1, RAM bank 0, ROM bank count 2, RAM bank
// count 0, no RAM, not a rumble cart; out_ch is empty.
module cartridge_bank_mapper (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cbm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cbm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	cbm_in_if.sink                           in_ch,
	cbm_out_if.source                        out_ch
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q;

	logic [cbm_pkg::ROM_CNT_W-1:0] rom_count_q;
	logic [cbm_pkg::RAM_CNT_W-1:0] ram_count_q;
	logic                          ram_present_q;
	logic                          rumble_q;

	logic                          ram_en_q;
	logic [cbm_pkg::ROM_SEL_W-1:0] rom_sel_q;
	logic [cbm_pkg::RAM_SEL_W-1:0] ram_sel_q;

	logic                          pend_rom_q;
	logic [13:0]                   pend_addr_q;
	cbm_pkg::cbm_target_t          res_target_q;
	logic [cbm_pkg::OFFSET_W-1:0]  res_off_q;

	logic                          out_valid_q;
	cbm_pkg::cbm_target_t          out_target_q;
	logic [cbm_pkg::OFFSET_W-1:0]  out_off_q;

	cbm_pkg::cbm_mod_req_t         mreq;
	cbm_pkg::cbm_mod_rsp_t         mrsp;

	logic                          in_xfer;
	logic                          is_wr;
	logic                          is_ctrl;
	logic                          is_fixed;
	logic                          is_brom;
	logic                          is_ramwin;
	logic                          ram_ok;
	logic                          needs_mod;
	cbm_pkg::cbm_target_t          dec_target;
	logic [cbm_pkg::OFFSET_W-1:0]  dec_off;
	logic [cbm_pkg::OFFSET_W-1:0]  mod_off;
	logic                          out_free;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;

	assign is_wr     = in_ch.op;
	assign is_ctrl   = is_wr && (in_ch.bus_addr <= cbm_pkg::CTRL_LAST_ADDR);
	assign is_fixed  = !is_wr && (in_ch.bus_addr[15:14] == 2'b00);
	assign is_brom   = !is_wr && (in_ch.bus_addr[15:14] == 2'b01);
	assign is_ramwin = (in_ch.bus_addr[15:13] == 3'b101);
	assign ram_ok    = ram_en_q && ram_present_q;
	assign needs_mod = !is_ctrl && (is_brom || (is_ramwin && ram_ok));

	always_comb begin
		dec_target = cbm_pkg::TGT_OTHER;
		dec_off    = '0;
		if (is_ctrl) begin
			dec_target = cbm_pkg::TGT_CONTROL;
		end else if (is_fixed) begin
			dec_target = cbm_pkg::TGT_FIXED_ROM;
			dec_off    = cbm_pkg::OFFSET_W'(in_ch.bus_addr[13:0]);
		end else if (is_brom) begin
			dec_target = cbm_pkg::TGT_BANK_ROM;
		end else if (is_ramwin) begin
			dec_target = ram_ok ? cbm_pkg::TGT_CART_RAM : cbm_pkg::TGT_RAM_OFF;
		end
	end

	assign mreq.start    = in_xfer && needs_mod;
	assign mreq.dividend = is_brom ? rom_sel_q : cbm_pkg::DVD_W'(ram_sel_q);
	assign mreq.divisor  = is_brom ? rom_count_q : cbm_pkg::DVS_W'(ram_count_q);

	cbm_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	// bank * 0x4000 + low 14 bits, or bank * 0x2000 + low 13 bits
	assign mod_off = pend_rom_q
		? {mrsp.rem[cbm_pkg::ROM_SEL_W-1:0], pend_addr_q}
		: cbm_pkg::OFFSET_W'({mrsp.rem[cbm_pkg::RAM_SEL_W-1:0], pend_addr_q[12:0]});

	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) state_q <= needs_mod ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					if (mrsp.done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_count_q   <= cbm_pkg::ROM_COUNT_RST;
			ram_count_q   <= '0;
			ram_present_q <= 1'b0;
			rumble_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				cbm_pkg::CFG_ROM_BANK_COUNT: rom_count_q <= cfg_wdata;
				cbm_pkg::CFG_RAM_BANK_COUNT: ram_count_q <= cfg_wdata[cbm_pkg::RAM_CNT_W-1:0];
				cbm_pkg::CFG_RAM_PRESENT:    ram_present_q <= cfg_wdata[0];
				cbm_pkg::CFG_RUMBLE_CART:    rumble_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// mapper control registers, written by bus writes below 0x6000
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_en_q  <= 1'b0;
			rom_sel_q <= cbm_pkg::ROM_SEL_RST;
			ram_sel_q <= '0;
		end else if (in_xfer && is_ctrl) begin
			case (in_ch.bus_addr[14:12])
				3'd0, 3'd1: ram_en_q <= (in_ch.wdata == cbm_pkg::RAM_EN_KEY);
				3'd2:       rom_sel_q[7:0] <= in_ch.wdata;
				3'd3:       rom_sel_q[8] <= in_ch.wdata[0];
				default: begin
					ram_sel_q <= rumble_q ? {1'b0, in_ch.wdata[2:0]} : in_ch.wdata[3:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pend_rom_q   <= is_brom;
			pend_addr_q  <= in_ch.bus_addr[13:0];
			res_target_q <= dec_target;
			res_off_q    <= dec_off;
		end else if (state_q == ST_DIV && mrsp.done) begin
			res_off_q <= mod_off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_target_q <= res_target_q;
			out_off_q    <= res_off_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.target       = out_target_q;
	assign out_ch.phys_offset  = out_off_q;
	assign out_ch.ram_writable = (out_target_q == cbm_pkg::TGT_CART_RAM);

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam logic            OP_READ     = 1'b0;
	localparam logic            OP_WRITE    = 1'b1;
	localparam logic [cbm_pkg::ADDR_W-1:0] FIXED_HI    = 16'h3FFF;
	localparam logic [cbm_pkg::ADDR_W-1:0] BANK_WIN_LO = 16'h4000;
	localparam logic [cbm_pkg::ADDR_W-1:0] BANKED_HI   = 16'h7FFF;
	localparam logic [cbm_pkg::ADDR_W-1:0] RAM_WIN_LO  = 16'hA000;
	localparam logic [cbm_pkg::ADDR_W-1:0] RAM_WIN_HI  = 16'hBFFF;
	localparam int unsigned     ROM_BANK_SIZE = 32'h4000;
	localparam int unsigned     RAM_BANK_SIZE = 32'h2000;
	localparam int unsigned     SETTLE_CYCLES = 16;
	localparam int unsigned     ITEMS_PER_PHASE = 255;

	typedef struct packed {
		cbm_pkg::cbm_target_t         target;
		logic [cbm_pkg::OFFSET_W-1:0] offset;
		logic                         writable;
	} bank_map_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [cbm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [cbm_pkg::CFG_DATA_W-1:0] cfg_wdata;

	cbm_in_if  in_ch ();
	cbm_out_if out_ch ();

	cartridge_bank_mapper i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// mapper model state and configuration
	logic                          ram_en;
	logic [cbm_pkg::ROM_SEL_W-1:0] rom_sel;
	logic [cbm_pkg::RAM_SEL_W-1:0] ram_sel;
	logic [cbm_pkg::ROM_CNT_W-1:0] rom_cnt;
	logic [cbm_pkg::RAM_CNT_W-1:0] ram_cnt;
	logic                          ram_pres;
	logic                          rumble;

	bank_map_t pending_maps[$];
	int unsigned mismatch_count;
	logic idle_on;

	always #1 clk = ~clk;

	function automatic bank_map_t map_access(input logic op,
		input logic [cbm_pkg::ADDR_W-1:0] addr, input logic [cbm_pkg::DATA_W-1:0] data);
		bank_map_t r;
		logic [cbm_pkg::ROM_CNT_W-1:0] bank;
		r.target   = cbm_pkg::TGT_OTHER;
		r.offset   = '0;
		bank       = '0;
		if (op == OP_WRITE && addr <= cbm_pkg::CTRL_LAST_ADDR) begin
			case (addr[15:12])
				4'h0, 4'h1: ram_en = (data == cbm_pkg::RAM_EN_KEY);
				4'h2: rom_sel[7:0] = data;
				4'h3: rom_sel[8] = data[0];
				default: ram_sel = rumble ? {1'b0, data[2:0]} : data[3:0];
			endcase
			r.target = cbm_pkg::TGT_CONTROL;
		end else if (op == OP_READ && addr <= FIXED_HI) begin
			r.target = cbm_pkg::TGT_FIXED_ROM;
			r.offset = cbm_pkg::OFFSET_W'(addr);
		end else if (op == OP_READ && addr <= BANKED_HI) begin
			if (rom_cnt != '0)
				bank = cbm_pkg::ROM_CNT_W'({1'b0, rom_sel} % rom_cnt);
			r.target = cbm_pkg::TGT_BANK_ROM;
			r.offset = cbm_pkg::OFFSET_W'(bank * ROM_BANK_SIZE + (addr - BANK_WIN_LO));
		end else if (addr >= RAM_WIN_LO && addr <= RAM_WIN_HI) begin
			if (ram_en && ram_pres) begin
				if (ram_cnt != '0)
					bank = cbm_pkg::ROM_CNT_W'({1'b0, ram_sel} % ram_cnt);
				r.target = cbm_pkg::TGT_CART_RAM;
				r.offset = cbm_pkg::OFFSET_W'(bank * RAM_BANK_SIZE + (addr - RAM_WIN_LO));
			end else begin
				r.target = cbm_pkg::TGT_RAM_OFF;
			end
		end
		r.writable = (r.target == cbm_pkg::TGT_CART_RAM);
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input bank_map_t want);
		if (mismatch_count < 10)
			$display("%0t: %s: expected target %0d offset 0x%06h wr %0b, got %0d 0x%06h %0b",
				$realtime, what, want.target, want.offset, want.writable,
				out_ch.target, out_ch.phys_offset, out_ch.ram_writable);
		mismatch_count++;
	endtask

	always @(negedge clk) begin
		out_ch.ready = !(idle_on && $urandom_range(99) < 9);
	end

	always @(posedge clk) begin : result_check
		bank_map_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_maps.size() == 0) begin
				want = '0;
				flag_mismatch("unexpected result", want);
			end else begin
				want = pending_maps.pop_front();
				if (out_ch.target !== want.target || out_ch.phys_offset !== want.offset ||
					out_ch.ram_writable !== want.writable)
					flag_mismatch("mismatch", want);
			end
		end
	end

	// called at a falling edge; returns at a falling edge with valid still high
	task automatic send_access(input logic op, input logic [cbm_pkg::ADDR_W-1:0] addr,
		input logic [cbm_pkg::DATA_W-1:0] data);
		logic taken;
		if (idle_on && $urandom_range(99) < 9) begin
			in_ch.valid = 1'b0;
			do @(negedge clk); while (idle_on && $urandom_range(99) < 9);
		end
		in_ch.valid    = 1'b1;
		in_ch.op       = op;
		in_ch.bus_addr = addr;
		in_ch.wdata    = data;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = in_ch.ready;
			if (taken)
				pending_maps.push_back(map_access(op, addr, data));
			@(negedge clk);
		end
	endtask

	task automatic drain_mapper();
		in_ch.valid = 1'b0;
		while (pending_maps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [cbm_pkg::CFG_IDX_W-1:0] idx,
		input logic [cbm_pkg::CFG_DATA_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			cbm_pkg::CFG_ROM_BANK_COUNT: rom_cnt  = val[cbm_pkg::ROM_CNT_W-1:0];
			cbm_pkg::CFG_RAM_BANK_COUNT: ram_cnt  = val[cbm_pkg::RAM_CNT_W-1:0];
			cbm_pkg::CFG_RAM_PRESENT:    ram_pres = val[0];
			default:                     rumble   = val[0];
		endcase
	endtask

	task automatic set_config(input logic [cbm_pkg::CFG_DATA_W-1:0] roms,
		input logic [cbm_pkg::CFG_DATA_W-1:0] rams,
		input logic [cbm_pkg::CFG_DATA_W-1:0] pres,
		input logic [cbm_pkg::CFG_DATA_W-1:0] rmb);
		drain_mapper();
		write_reg(cbm_pkg::CFG_ROM_BANK_COUNT, roms);
		write_reg(cbm_pkg::CFG_RAM_BANK_COUNT, rams);
		write_reg(cbm_pkg::CFG_RAM_PRESENT, pres);
		write_reg(cbm_pkg::CFG_RUMBLE_CART, rmb);
	endtask

	task automatic test_reset_defaults();
		send_access(OP_READ,  16'h0000, 8'hFF);
		send_access(OP_READ,  16'h3FFF, 8'h00);
		send_access(OP_READ,  16'h4000, 8'h00);
		send_access(OP_READ,  16'h7FFF, 8'hFF);
		send_access(OP_READ,  16'hA000, 8'h00);
		send_access(OP_WRITE, 16'hBFFF, 8'h5A);
		send_access(OP_WRITE, 16'h6000, 8'hFF);
		send_access(OP_READ,  16'h8000, 8'h00);
		send_access(OP_WRITE, 16'hFFFF, 8'hFF);
	endtask

	task automatic test_control_writes();
		set_config(10'd512, 10'd16, 10'd1, 10'd0);
		send_access(OP_WRITE, 16'h0000, cbm_pkg::RAM_EN_KEY);
		send_access(OP_READ,  16'hA000, 8'h00);
		send_access(OP_WRITE, 16'h4000, 8'hFF);
		send_access(OP_WRITE, 16'hBFFF, 8'h11);
		send_access(OP_WRITE, 16'h2000, 8'hFF);
		send_access(OP_WRITE, 16'h3FFF, 8'h01);
		send_access(OP_READ,  16'h7FFF, 8'h00);
		send_access(OP_WRITE, 16'h1FFF, 8'h0B);
		send_access(OP_READ,  16'hA123, 8'h00);
		send_access(OP_WRITE, 16'h2FFF, 8'h00);
		send_access(OP_WRITE, 16'h3000, 8'hFE);
		send_access(OP_READ,  16'h4000, 8'h00);
	endtask

	// rumble bank masking, zero bank counts, counts past the nominal range
	task automatic test_bank_count_edges();
		set_config(10'd0, 10'd0, 10'd1, 10'd1);
		send_access(OP_WRITE, 16'h0000, cbm_pkg::RAM_EN_KEY);
		send_access(OP_WRITE, 16'h5FFF, 8'hFF);
		send_access(OP_READ,  16'hA001, 8'h00);
		send_access(OP_READ,  16'h5555, 8'h00);
		set_config(10'd1023, 10'd31, 10'd1, 10'd1);
		send_access(OP_WRITE, 16'h2000, 8'hFF);
		send_access(OP_WRITE, 16'h3000, 8'hFF);
		send_access(OP_READ,  16'h7FFF, 8'h00);
		send_access(OP_READ,  16'hBFFF, 8'h00);
	endtask

	task automatic random_access();
		int unsigned kind;
		logic op;
		logic [cbm_pkg::ADDR_W-1:0] addr;
		logic [cbm_pkg::DATA_W-1:0] data;
		kind = $urandom_range(99);
		op   = OP_WRITE;
		data = cbm_pkg::DATA_W'($urandom);
		if (kind < 12) begin
			addr = cbm_pkg::ADDR_W'($urandom_range(16'h1FFF, 16'h0000));
			if ($urandom_range(1))
				data = cbm_pkg::RAM_EN_KEY;
		end else if (kind < 20) begin
			addr = cbm_pkg::ADDR_W'($urandom_range(16'h2FFF, 16'h2000));
		end else if (kind < 26) begin
			addr = cbm_pkg::ADDR_W'($urandom_range(16'h3FFF, 16'h3000));
		end else if (kind < 34) begin
			addr = cbm_pkg::ADDR_W'($urandom_range(16'h5FFF, 16'h4000));
		end else if (kind < 44) begin
			op   = OP_READ;
			addr = cbm_pkg::ADDR_W'($urandom_range(FIXED_HI, 16'h0000));
		end else if (kind < 60) begin
			op   = OP_READ;
			addr = cbm_pkg::ADDR_W'($urandom_range(BANKED_HI, BANK_WIN_LO));
		end else if (kind < 82) begin
			op   = 1'($urandom_range(1));
			addr = cbm_pkg::ADDR_W'($urandom_range(RAM_WIN_HI, RAM_WIN_LO));
		end else if (kind < 90) begin
			op   = 1'($urandom_range(1));
			addr = op ? cbm_pkg::ADDR_W'($urandom_range(16'h7FFF, 16'h6000))
				: cbm_pkg::ADDR_W'($urandom_range(16'hFFFF, 16'h8000));
		end else begin
			op   = 1'($urandom_range(1));
			addr = cbm_pkg::ADDR_W'($urandom);
		end
		send_access(op, addr, data);
	endtask

	task automatic test_random_accesses();
		logic [cbm_pkg::CFG_DATA_W-1:0] roms, rams, pres, rmb;
		for (int p = 0; p < 6; p++) begin
			case ($urandom_range(3))
				0: roms = cbm_pkg::CFG_DATA_W'($urandom_range(512, 1));
				1: roms = cbm_pkg::CFG_DATA_W'($urandom);
				2: roms = 10'd1 << $urandom_range(9);
				default: roms = '0;
			endcase
			case ($urandom_range(3))
				0: rams = cbm_pkg::CFG_DATA_W'($urandom_range(16, 1));
				1: rams = cbm_pkg::CFG_DATA_W'($urandom);
				2: rams = 10'd1 << $urandom_range(4);
				default: rams = '0;
			endcase
			pres = cbm_pkg::CFG_DATA_W'($urandom_range(3) != 0);
			rmb  = cbm_pkg::CFG_DATA_W'($urandom_range(1));
			// upper data bits are don't-care for the narrow registers
			if (p >= 3) begin
				pres = pres | cbm_pkg::CFG_DATA_W'($urandom & 32'h3FE);
				rmb  = rmb | cbm_pkg::CFG_DATA_W'($urandom & 32'h3FE);
			end
			if (p == 0) begin
				roms = 10'd512;
				rams = 10'd16;
				pres = 10'd1;
				rmb  = 10'd1;
			end else if (p == 1) begin
				roms = 10'd1;
				rams = 10'd1;
				pres = 10'd1;
				rmb  = 10'd0;
			end
			set_config(roms, rams, pres, rmb);
			idle_on = (p != 2);
			repeat (ITEMS_PER_PHASE) random_access();
		end
		idle_on = 1'b1;
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		in_ch.valid    = 1'b0;
		in_ch.op       = OP_READ;
		in_ch.bus_addr = '0;
		in_ch.wdata    = '0;
		out_ch.ready   = 1'b0;
		idle_on        = 1'b1;
		mismatch_count = 0;
		ram_en         = 1'b0;
		rom_sel        = cbm_pkg::ROM_SEL_RST;
		ram_sel        = '0;
		rom_cnt        = cbm_pkg::ROM_COUNT_RST;
		ram_cnt        = '0;
		ram_pres       = 1'b0;
		rumble         = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_control_writes();
		test_bank_count_edges();
		test_random_accesses();

		drain_mapper();
		if (mismatch_count == 0 && pending_maps.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#1000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== files.f =====
sv/cbm_pkg.sv
sv/cbm_if.sv
sv/cbm_mod_unit.sv
sv/cartridge_bank_mapper.sv
bench/testbench.sv
